// ----- src/multi_channel_blink_timer_defines.svh -----
// Assertion macros for the multi-channel blink timer.
// No dependencies; included by modules that carry assertions.
`ifndef MULTI_CHANNEL_BLINK_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_BLINK_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MCBT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define MCBT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define MCBT_ASSERT(label, clk, rst, prop)
`define MCBT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- src/mcbt_pkg.sv -----
// Package for the multi-channel blink timer: command codes, field widths
// and default channel count. No dependencies.
package mcbt_pkg;

   localparam int DEFAULT_NUM_CHANNELS = 4;

   localparam int CMD_W     = 2;   // command field
   localparam int CHAN_W    = 2;   // channel field
   localparam int TICK_W    = 16;  // on, off and repeat fields
   localparam int MASK_W    = 4;   // mute, led and active masks

   // req_tdata: channel, on_ticks, off_ticks, repeat_count, padded to bytes
   localparam int REQ_FIELD_W = CHAN_W + 3 * TICK_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((2 * MASK_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } command_type;

   typedef logic [TICK_W-1:0] tick_type;

endpackage

// ----- src/multi_channel_blink_timer.sv -----
// Multi-channel blink timer top level: per-channel on/off pattern state,
// command decode and a two-word result buffer. Uses mcbt_pkg and the defines header.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------------
//   req     | in  | req_tvalid/req_tready  | tuser: command; tdata: chan, on, off, rep
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: led_on_mask, active_mask
//   csr     | in  | csr_valid/csr_ready    | csr_data: mute_mask
//
// One word per cycle while req_tready is high; all channels update in the accept cycle.
// The result is captured on accept and, unless rsp stalls, offered the next cycle.
// A word accepted while rsp is stalled parks in the skid entry; req_tready is low
// while that entry is held and rises the cycle after it moves to the output.
// Synchronous active-high reset clears all channel state, mute mask and buffers.
// csr_ready is always high; writes take effect on the next word.
`include "multi_channel_blink_timer_defines.svh"

module multi_channel_blink_timer #(
   parameter int NUM_CHANNELS = mcbt_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                           clock,
   input  logic                           reset,
   // request words
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mcbt_pkg::CMD_W-1:0]     req_tuser,   // [1:0] command
   input  logic [mcbt_pkg::REQ_DATA_W-1:0] req_tdata,  // [1:0] channel, [17:2] on_ticks,
                                                       // [33:18] off_ticks,
                                                       // [49:34] repeat_count, rest zero
   // result words
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mcbt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [3:0] led_on_mask,
                                                       // [7:4] active_mask
   // mute mask register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcbt_pkg::MASK_W-1:0]    csr_data     // [3:0] mute_mask
);
   import mcbt_pkg::*;

   localparam int NC     = NUM_CHANNELS;
   localparam int OUT_N  = (NC < MASK_W) ? NC : MASK_W;  // channels visible in masks
   localparam int MUTE_N = (NC < MASK_W) ? NC : MASK_W;  // channels that can be muted

   // ---------------------------------------------------------------------
   // Request field unpack
   // ---------------------------------------------------------------------
   command_type         cmd;
   logic [CHAN_W-1:0]   req_channel;
   tick_type            req_on;
   tick_type            req_off;
   tick_type            req_rep;

   assign cmd         = command_type'(req_tuser);
   assign req_channel = req_tdata[CHAN_W-1:0];
   assign req_on      = req_tdata[CHAN_W +: TICK_W];
   assign req_off     = req_tdata[CHAN_W + TICK_W +: TICK_W];
   assign req_rep     = req_tdata[CHAN_W + 2*TICK_W +: TICK_W];

   // ---------------------------------------------------------------------
   // Channel state
   // ---------------------------------------------------------------------
   tick_type   on_len_ff   [NC];
   tick_type   off_len_ff  [NC];
   tick_type   rep_tgt_ff  [NC];
   tick_type   phase_ff    [NC];
   tick_type   periods_ff  [NC];
   logic [NC-1:0] off_phase_ff;
   logic [NC-1:0] running_ff;
   logic [NC-1:0] lamp_ff;

   tick_type   on_len_in   [NC];
   tick_type   off_len_in  [NC];
   tick_type   rep_tgt_in  [NC];
   tick_type   phase_in    [NC];
   tick_type   periods_in  [NC];
   logic [NC-1:0] off_phase_in;
   logic [NC-1:0] running_in;
   logic [NC-1:0] lamp_in;

   logic [MASK_W-1:0] mute_ff;

   logic [NC-1:0]     muted;
   logic [NC-1:0]     on_zero;    // channel has zero on time loaded
   logic              req_fire;
   logic [RSP_DATA_W-1:0] result;

   assign req_fire  = req_tvalid & req_tready;
   assign csr_ready = 1'b1;

   // mute applies to the low channels only
   always_comb begin
      muted = '0;
      for (int c = 0; c < MUTE_N; c++) begin
         muted[c] = mute_ff[c];
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         on_zero[c] = (on_len_ff[c] == '0);
      end
   end

   // Per-channel next state; channels are independent
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         tick_type ph_inc;
         tick_type pd_inc;
         logic     hit;

         ph_inc = phase_ff[c] + tick_type'(1);
         pd_inc = periods_ff[c] + tick_type'(1);
         hit    = (int'(req_channel) == c);

         on_len_in[c]    = on_len_ff[c];
         off_len_in[c]   = off_len_ff[c];
         rep_tgt_in[c]   = rep_tgt_ff[c];
         phase_in[c]     = phase_ff[c];
         periods_in[c]   = periods_ff[c];
         off_phase_in[c] = off_phase_ff[c];
         running_in[c]   = running_ff[c];
         lamp_in[c]      = lamp_ff[c];

         unique case (cmd)
            CMD_TICK: begin
               if (running_ff[c] && off_len_ff[c] != '0 && !muted[c]) begin
                  phase_in[c] = ph_inc;
                  if (!off_phase_ff[c]) begin
                     // on phase done -> go dark
                     if (ph_inc >= on_len_ff[c]) begin
                        lamp_in[c]      = 1'b0;
                        phase_in[c]     = '0;
                        off_phase_in[c] = 1'b1;
                     end
                  end else if (ph_inc >= off_len_ff[c]) begin
                     if (rep_tgt_ff[c] != '0 && pd_inc >= rep_tgt_ff[c]) begin
                        // last period: end with LED off, phase count kept
                        periods_in[c] = pd_inc;
                        running_in[c] = 1'b0;
                        off_len_in[c] = '0;
                     end else begin
                        if (rep_tgt_ff[c] != '0) begin
                           periods_in[c] = pd_inc;
                        end
                        phase_in[c]     = '0;
                        off_phase_in[c] = 1'b0;
                        lamp_in[c]      = 1'b1;
                     end
                  end
               end
            end
            CMD_START: begin
               if (hit && req_on != '0 && !muted[c]) begin
                  on_len_in[c]    = req_on;
                  off_len_in[c]   = req_off;
                  rep_tgt_in[c]   = req_rep;
                  phase_in[c]     = '0;
                  periods_in[c]   = '0;
                  off_phase_in[c] = 1'b0;
                  running_in[c]   = 1'b1;
                  lamp_in[c]      = 1'b1;
               end
            end
            CMD_STOP: begin
               if (hit) begin
                  running_in[c] = 1'b0;
                  // steady-on or endless pattern: force dark
                  if (off_len_ff[c] == '0 || rep_tgt_ff[c] == '0) begin
                     lamp_in[c] = 1'b0;
                  end
               end
            end
            default: begin
               // unused command code: state untouched
            end
         endcase
      end
   end

   // result word from the post-update state
   always_comb begin
      result = '0;
      for (int c = 0; c < OUT_N; c++) begin
         result[c]          = lamp_in[c];
         result[MASK_W + c] = running_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            on_len_ff[c]  <= '0;
            off_len_ff[c] <= '0;
            rep_tgt_ff[c] <= '0;
            phase_ff[c]   <= '0;
            periods_ff[c] <= '0;
         end
         off_phase_ff <= '0;
         running_ff   <= '0;
         lamp_ff      <= '0;
      end else if (req_fire) begin
         for (int c = 0; c < NC; c++) begin
            on_len_ff[c]  <= on_len_in[c];
            off_len_ff[c] <= off_len_in[c];
            rep_tgt_ff[c] <= rep_tgt_in[c];
            phase_ff[c]   <= phase_in[c];
            periods_ff[c] <= periods_in[c];
         end
         off_phase_ff <= off_phase_in;
         running_ff   <= running_in;
         lamp_ff      <= lamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         mute_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Result register with one skid entry
   // ---------------------------------------------------------------------
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  skid_valid_ff;
   logic [RSP_DATA_W-1:0] skid_data_ff;

   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_tready) begin
         // output stalled: park a new word in the skid entry
         if (req_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_tready) begin
         if (req_fire) begin
            skid_data_ff <= result;
         end
      end else if (skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (req_fire) begin
         out_data_ff <= result;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `MCBT_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff)
   `MCBT_ASSERT(a_stall_parks_word, clock, reset, (req_fire && rsp_tvalid && !rsp_tready) |=> skid_valid_ff)
   `MCBT_NEVER(a_dark_in_off_phase, clock, reset, |(running_ff & off_phase_ff & lamp_ff))
   `MCBT_NEVER(a_running_has_on_time, clock, reset, |(running_ff & on_zero))

endmodule
